// ===== design/ahfr_pkg.sv =====
`timescale 1ns / 1ps
package ahfr_pkg;

	localparam int unsigned RX_BUFFER_BYTES_DEF = 512;
	localparam int unsigned STATUS_BYTES_DEF    = 8;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEQ_MIN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DATA = 2'd2;

	localparam logic [15:0] TIMEOUT_RST  = 16'd1000;
	localparam logic [7:0]  SEQ_MIN_RST  = 8'd32;
	localparam logic [8:0]  MAX_DATA_RST = 9'd480;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_BYTE  = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	localparam logic [7:0] B_PRE  = 8'h01;
	localparam logic [7:0] B_EOT  = 8'h03;
	localparam logic [7:0] B_SEP  = 8'h04;
	localparam logic [7:0] B_PST  = 8'h05;
	localparam logic [7:0] B_NAK  = 8'h15;
	localparam logic [7:0] B_SYN  = 8'h16;
	localparam logic [7:0] HEX_LO = 8'h30;
	localparam logic [7:0] HEX_HI = 8'h3F;

	localparam logic [15:0] LEN_BIAS     = 16'h0020;
	localparam logic [15:0] POS_LEN_LAST = 16'd4;
	localparam logic [15:0] POS_SEQ      = 16'd5;
	localparam logic [15:0] POS_CMD_LO   = 16'd6;
	localparam logic [15:0] POS_CMD_HI   = 16'd9;
	localparam logic [15:0] POS_DATA     = 16'd10;
	localparam logic [15:0] BCC_CHARS    = 16'd4;
	localparam logic [15:0] TAIL_BYTES   = 16'd6;

	typedef enum logic [2:0] {
		E_OK,
		E_TIMEOUT,
		E_NAK,
		E_INVALID,
		E_BCC,
		E_OVERFLOW,
		E_SEQ,
		E_CMD
	} err_t;

	typedef enum logic [1:0] {
		REQ_START,
		REQ_BYTE,
		REQ_TICK
	} req_kind_t;

	typedef struct packed {
		logic is_hex;
		logic is_pre;
		logic is_eot;
		logic is_sep;
		logic is_pst;
		logic is_nak;
		logic is_syn;
		logic hi_bit;
	} byte_cls_t;

	typedef struct packed {
		req_kind_t   kind;
		logic [7:0]  data;
		byte_cls_t   cls;
		logic [7:0]  want_seq;
		logic [15:0] want_cmd;
	} req_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic logic [15:0] nib_push(input logic [15:0] w, input logic [7:0] b);
		logic [7:0] d;
		d = b - HEX_LO;
		return {w[11:0], d[3:0]};
	endfunction

endpackage

// ===== design/ahfr_if.sv =====
`timescale 1ns / 1ps
interface ahfr_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [7:0]  rx_byte;
	logic [7:0]  expected_seq;
	logic [15:0] expected_cmd;

	modport source(output valid, output cmd, output rx_byte, output expected_seq,
		output expected_cmd, input ready);
	modport sink(input valid, input cmd, input rx_byte, input expected_seq,
		input expected_cmd, output ready);
endinterface

interface ahfr_result_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  data_byte;
	logic [8:0]  data_index;
	logic [2:0]  error_code;
	logic [7:0]  resp_seq;
	logic [15:0] resp_cmd;
	logic [63:0] status_bytes;
	logic [8:0]  data_count;

	modport source(output valid, output kind, output data_byte, output data_index,
		output error_code, output resp_seq, output resp_cmd, output status_bytes,
		output data_count, input ready);
	modport sink(input valid, input kind, input data_byte, input data_index,
		input error_code, input resp_seq, input resp_cmd, input status_bytes,
		input data_count, output ready);
endinterface

// ===== design/ahfr_front.sv =====
`timescale 1ns / 1ps
module ahfr_front (
	ahfr_item_if.sink       item,
	input  ahfr_pkg::qstat_t q_stat,
	output logic            push,
	output ahfr_pkg::req_t  push_data
);
	import ahfr_pkg::*;

	logic known;

	assign item.ready = !q_stat.full;

	always_comb begin
		known          = 1'b1;
		push_data.kind = REQ_BYTE;
		unique case (item.cmd)
			CMD_START: push_data.kind = REQ_START;
			CMD_BYTE:  push_data.kind = REQ_BYTE;
			CMD_TICK:  push_data.kind = REQ_TICK;
			default:   known = 1'b0;
		endcase
		push_data.data         = item.rx_byte;
		push_data.want_seq     = item.expected_seq;
		push_data.want_cmd     = item.expected_cmd;
		push_data.cls.is_hex   = (item.rx_byte >= HEX_LO) && (item.rx_byte <= HEX_HI);
		push_data.cls.is_pre   = item.rx_byte == B_PRE;
		push_data.cls.is_eot   = item.rx_byte == B_EOT;
		push_data.cls.is_sep   = item.rx_byte == B_SEP;
		push_data.cls.is_pst   = item.rx_byte == B_PST;
		push_data.cls.is_nak   = item.rx_byte == B_NAK;
		push_data.cls.is_syn   = item.rx_byte == B_SYN;
		push_data.cls.hi_bit   = item.rx_byte[7];
	end

	// drop unknown commands here; they never reach the queue
	assign push = item.valid && !q_stat.full && known;

endmodule

// ===== design/ahfr_queue.sv =====
`timescale 1ns / 1ps
module ahfr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ahfr_pkg::req_t  push_data,
	input  logic            pop,
	output ahfr_pkg::req_t  head,
	output ahfr_pkg::qstat_t stat
);
	import ahfr_pkg::*;

	localparam int unsigned DEPTH = 2;
	localparam int unsigned AW    = $clog2(DEPTH);

	req_t           mem_q [DEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [AW:0]    cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head       = mem_q[rd_q];
	assign stat.full  = cnt_q == (AW+1)'(DEPTH);
	assign stat.empty = cnt_q == '0;

endmodule

// ===== design/ahfr_back.sv =====
`timescale 1ns / 1ps
module ahfr_back #(
	parameter int unsigned RX_BUFFER_BYTES = ahfr_pkg::RX_BUFFER_BYTES_DEF,
	parameter int unsigned STATUS_BYTES    = ahfr_pkg::STATUS_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ahfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ahfr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  ahfr_pkg::req_t                  head,
	input  ahfr_pkg::qstat_t                q_stat,
	output logic                            pop,
	ahfr_result_if.source                   result
);
	import ahfr_pkg::*;

	localparam int unsigned PW        = $clog2(RX_BUFFER_BYTES + 1);
	localparam int unsigned SW        = 8 * STATUS_BYTES;
	localparam int unsigned PAD       = 8 * (8 - STATUS_BYTES);
	localparam int unsigned MIN_RAW   = 11 + STATUS_BYTES;
	localparam int unsigned MIN_FRAME = MIN_RAW + 6;

	localparam logic [PW-1:0] CNT_FULL  = PW'(RX_BUFFER_BYTES);
	localparam logic [15:0]   LEN_MIN_W = LEN_BIAS + 16'(MIN_RAW);
	localparam logic [15:0]   SEP_OFS   = LEN_BIAS + 16'(STATUS_BYTES + 1);
	localparam logic [15:0]   FRAME_MIN = 16'(MIN_FRAME);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HUNT,
		PH_FRAME
	} phase_t;

	typedef struct packed {
		logic lenbad;
		logic cmdbad;
		logic bccbad;
		logic pstbad;
		logic sepbad;
		logic statbad;
		logic lenok;
	} flags_t;

	phase_t         phase_q, phase_d;
	logic [15:0]    win_q, win_d;
	logic [PW-1:0]  cnt_q, cnt_d;
	logic [15:0]    sum_q, sum_d;
	logic [15:0]    post_q, post_d;
	logic [15:0]    len_q, len_d;
	logic [15:0]    raw_q, raw_d;
	logic [15:0]    sep_q, sep_d;
	logic [15:0]    dl_q, dl_d;
	logic [7:0]     seq_q, seq_d;
	logic [15:0]    cmdw_q, cmdw_d;
	logic [15:0]    bcc_q, bcc_d;
	logic [SW-1:0]  stat_q, stat_d;
	flags_t         flg_q, flg_d;
	logic [7:0]     want_seq_q, want_seq_d;
	logic [15:0]    want_cmd_q, want_cmd_d;

	logic [15:0]    tmo_q;
	logic [7:0]     seq_min_q;
	logic [8:0]     max_data_q;

	logic           ovalid_q;
	logic           okind_q;
	logic [7:0]     obyte_q;
	logic [8:0]     oidx_q;
	err_t           oerr_q;
	logic [7:0]     oseq_q;
	logic [15:0]    ocmd_q;
	logic [63:0]    ostat_q;
	logic [8:0]     ocnt_q;

	logic           adv;
	logic           emit_v;
	logic           emit_d;
	err_t           verr;
	err_t           judge_err;
	logic [8:0]     didx;
	logic [15:0]    pe;
	logic [15:0]    bc_new;
	logic [15:0]    sum_add;
	logic [15:0]    new_lw;
	logic [15:0]    didx_w;
	logic           data_ok;
	logic [8:0]     dcount;
	logic [7:0]     b;

	assign adv     = !q_stat.empty && (!ovalid_q || result.ready);
	assign pop     = adv;
	assign b       = head.data;
	assign pe      = 16'(cnt_q);
	assign bc_new  = pe + 16'd1;
	assign sum_add = sum_q + 16'(b);
	assign new_lw  = nib_push(len_q, b);
	assign didx_w  = pe - POS_DATA;
	assign data_ok = flg_q.lenok && (dl_q <= 16'(max_data_q));
	assign dcount  = data_ok ? dl_q[8:0] : 9'd0;

	always_comb begin
		priority if (bc_new < FRAME_MIN) begin
			judge_err = E_INVALID;
		end else if (!flg_q.lenok) begin
			judge_err = E_INVALID;
		end else if (dl_q > 16'(max_data_q)) begin
			judge_err = E_INVALID;
		end else if (bc_new != raw_q + TAIL_BYTES) begin
			judge_err = E_INVALID;
		end else if (flg_q.pstbad || flg_q.bccbad) begin
			judge_err = E_INVALID;
		end else if (post_q != bcc_q) begin
			judge_err = E_BCC;
		end else if (seq_q < seq_min_q) begin
			judge_err = E_INVALID;
		end else if (flg_q.cmdbad || flg_q.sepbad || flg_q.statbad) begin
			judge_err = E_INVALID;
		end else if (seq_q != want_seq_q) begin
			judge_err = E_SEQ;
		end else if (cmdw_q != want_cmd_q) begin
			judge_err = E_CMD;
		end else begin
			judge_err = E_OK;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		win_d      = win_q;
		cnt_d      = cnt_q;
		sum_d      = sum_q;
		post_d     = post_q;
		len_d      = len_q;
		raw_d      = raw_q;
		sep_d      = sep_q;
		dl_d       = dl_q;
		seq_d      = seq_q;
		cmdw_d     = cmdw_q;
		bcc_d      = bcc_q;
		stat_d     = stat_q;
		flg_d      = flg_q;
		want_seq_d = want_seq_q;
		want_cmd_d = want_cmd_q;
		emit_v     = 1'b0;
		emit_d     = 1'b0;
		verr       = E_OK;
		didx       = didx_w[8:0];

		if (adv) begin
			unique case (head.kind)
				REQ_START: begin
					phase_d    = PH_HUNT;
					win_d      = '0;
					cnt_d      = '0;
					sum_d      = '0;
					post_d     = '0;
					len_d      = '0;
					raw_d      = '0;
					sep_d      = '0;
					dl_d       = '0;
					seq_d      = '0;
					cmdw_d     = '0;
					bcc_d      = '0;
					stat_d     = '0;
					flg_d      = '0;
					want_seq_d = head.want_seq;
					want_cmd_d = head.want_cmd;
				end
				REQ_TICK: begin
					if (phase_q != PH_IDLE) begin
						if (win_q != 16'hFFFF) begin
							win_d = win_q + 16'd1;
						end
						if (win_d >= tmo_q) begin
							emit_v = 1'b1;
							verr   = E_TIMEOUT;
						end
					end
				end
				REQ_BYTE: begin
					if (phase_q == PH_HUNT) begin
						priority if (head.cls.is_nak) begin
							emit_v = 1'b1;
							verr   = E_NAK;
						end else if (head.cls.is_syn) begin
							win_d = '0;
						end else if (head.cls.is_pre) begin
							phase_d = PH_FRAME;
							cnt_d   = PW'(1);
						end
					end else if (phase_q == PH_FRAME) begin
						priority if (cnt_q >= CNT_FULL) begin
							emit_v = 1'b1;
							verr   = E_OVERFLOW;
						end else if (head.cls.is_eot) begin
							cnt_d  = cnt_q + 1'b1;
							emit_v = 1'b1;
							verr   = judge_err;
						end else if (pe <= POS_LEN_LAST) begin
							cnt_d        = cnt_q + 1'b1;
							flg_d.lenbad = flg_q.lenbad || !head.cls.is_hex;
							len_d        = new_lw;
							raw_d        = new_lw - LEN_BIAS;
							sep_d        = new_lw - SEP_OFS;
							dl_d         = new_lw - LEN_MIN_W;
							sum_d        = sum_add;
							if (pe == POS_LEN_LAST && !flg_d.lenbad && new_lw >= LEN_MIN_W) begin
								flg_d.lenok = 1'b1;
							end
						end else begin
							cnt_d = cnt_q + 1'b1;
							if (pe == POS_SEQ) begin
								seq_d = b;
							end
							if (pe >= POS_CMD_LO && pe <= POS_CMD_HI) begin
								flg_d.cmdbad = flg_q.cmdbad || !head.cls.is_hex;
								cmdw_d       = nib_push(cmdw_q, b);
							end
							if (flg_q.lenok) begin
								if (pe <= raw_q) begin
									sum_d = sum_add;
								end
								if (pe == raw_q) begin
									post_d       = sum_add;
									flg_d.pstbad = flg_q.pstbad || !head.cls.is_pst;
								end
								if (pe > raw_q && pe <= raw_q + BCC_CHARS) begin
									flg_d.bccbad = flg_q.bccbad || !head.cls.is_hex;
									bcc_d        = nib_push(bcc_q, b);
								end
								if (pe == sep_q && !head.cls.is_sep) begin
									flg_d.sepbad = 1'b1;
								end
								if (pe > sep_q && pe < raw_q) begin
									flg_d.statbad = flg_q.statbad || !head.cls.hi_bit;
									stat_d        = (stat_q << 8) | SW'(b);
								end
								if (data_ok && pe >= POS_DATA && pe < sep_q) begin
									emit_d = 1'b1;
								end
							end
						end
					end
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
			if (emit_v) begin
				phase_d = PH_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			win_q      <= '0;
			cnt_q      <= '0;
			sum_q      <= '0;
			post_q     <= '0;
			len_q      <= '0;
			raw_q      <= '0;
			sep_q      <= '0;
			dl_q       <= '0;
			seq_q      <= '0;
			cmdw_q     <= '0;
			bcc_q      <= '0;
			stat_q     <= '0;
			flg_q      <= '0;
			want_seq_q <= '0;
			want_cmd_q <= '0;
			tmo_q      <= TIMEOUT_RST;
			seq_min_q  <= SEQ_MIN_RST;
			max_data_q <= MAX_DATA_RST;
			ovalid_q   <= 1'b0;
		end else begin
			phase_q    <= phase_d;
			win_q      <= win_d;
			cnt_q      <= cnt_d;
			sum_q      <= sum_d;
			post_q     <= post_d;
			len_q      <= len_d;
			raw_q      <= raw_d;
			sep_q      <= sep_d;
			dl_q       <= dl_d;
			seq_q      <= seq_d;
			cmdw_q     <= cmdw_d;
			bcc_q      <= bcc_d;
			stat_q     <= stat_d;
			flg_q      <= flg_d;
			want_seq_q <= want_seq_d;
			want_cmd_q <= want_cmd_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_TIMEOUT:  tmo_q      <= cfg_data[15:0];
					CFG_SEQ_MIN:  seq_min_q  <= cfg_data[7:0];
					CFG_MAX_DATA: max_data_q <= cfg_data[8:0];
					default:      tmo_q      <= tmo_q;
				endcase
			end
			if (adv) begin
				ovalid_q <= emit_v || emit_d;
			end else if (result.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// load the result register whenever a request advances with a result
	always_ff @(posedge clk) begin
		if (adv && emit_v) begin
			okind_q <= 1'b1;
			obyte_q <= '0;
			oidx_q  <= '0;
			oerr_q  <= verr;
			oseq_q  <= seq_q;
			ocmd_q  <= cmdw_q;
			ostat_q <= 64'(stat_q) << PAD;
			ocnt_q  <= dcount;
		end else if (adv && emit_d) begin
			okind_q <= 1'b0;
			obyte_q <= b;
			oidx_q  <= didx;
			oerr_q  <= E_OK;
			oseq_q  <= '0;
			ocmd_q  <= '0;
			ostat_q <= '0;
			ocnt_q  <= '0;
		end
	end

	assign result.valid        = ovalid_q;
	assign result.kind         = okind_q;
	assign result.data_byte    = obyte_q;
	assign result.data_index   = oidx_q;
	assign result.error_code   = oerr_q;
	assign result.resp_seq     = oseq_q;
	assign result.resp_cmd     = ocmd_q;
	assign result.status_bytes = ostat_q;
	assign result.data_count   = ocnt_q;

endmodule

// ===== design/ascii_hex_frame_receiver.sv =====
// Channel   Dir   Payload
// item      in    cmd, rx_byte, expected_seq, expected_cmd
// result    out   kind, data_byte, data_index, error_code, resp_seq, resp_cmd,
//                 status_bytes, data_count
// cfg       in    cfg_we, cfg_index, cfg_data (write only)
//
// One request per cycle while the queue is not full; an accepted request is
// classified and written into a two-entry queue, then a deframer step takes it
// from the queue head and loads any result into the result register.
// Each deframer step handles one request and yields at most one result.
// A result stalled at the output holds the deframer; the queue keeps taking
// requests until it is full.
// arst_n clears all control state and loads the register reset values.
`timescale 1ns / 1ps
module ascii_hex_frame_receiver #(
	parameter int unsigned RX_BUFFER_BYTES = ahfr_pkg::RX_BUFFER_BYTES_DEF,
	parameter int unsigned STATUS_BYTES    = ahfr_pkg::STATUS_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	ahfr_item_if.sink                       item,
	ahfr_result_if.source                   result,
	input  logic                            cfg_we,
	input  logic [ahfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ahfr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ahfr_pkg::*;

	logic   push;
	req_t   push_data;
	logic   pop;
	req_t   head;
	qstat_t q_stat;

	ahfr_front u_front (
		.item      (item),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	ahfr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	ahfr_back #(
		.RX_BUFFER_BYTES (RX_BUFFER_BYTES),
		.STATUS_BYTES    (STATUS_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.result    (result)
	);

`ifndef ASSERT_OFF
	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.kind) |-> (result.error_code == E_OK &&
		result.resp_seq == 8'd0 && result.resp_cmd == 16'd0 &&
		result.status_bytes == 64'd0 && result.data_count == 9'd0))
		else $error("data result carries verdict fields");

	a_pop_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !(result.valid && !result.ready))
		else $error("request taken while result stalled");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	a_queue_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue both full and empty");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import ahfr_pkg::*;

	localparam int unsigned STAT_LEN       = 8;
	localparam int unsigned LEN_FLOOR      = 11 + STAT_LEN;
	localparam int unsigned FRAME_FLOOR    = LEN_FLOOR + 6;
	localparam int unsigned TAIL_LEN       = 6;
	localparam int unsigned BUF_BYTES      = 512;
	localparam int unsigned DATA_POS       = 10;
	localparam int unsigned DRAIN_CYCLES   = 12;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam logic [1:0]  CMD_UNUSED     = 2'd3;

	typedef enum logic [1:0] {
		RX_IDLE,
		RX_HUNT,
		RX_FRAME
	} rx_phase_t;

	typedef struct {
		logic        kind;
		logic [7:0]  data_byte;
		logic [8:0]  data_index;
		err_t        error_code;
		logic [7:0]  resp_seq;
		logic [15:0] resp_cmd;
		logic [63:0] status_bytes;
		logic [8:0]  data_count;
	} rx_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ahfr_item_if item_ch();
	ahfr_result_if result_ch();

	ascii_hex_frame_receiver u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// deframer state as the block should hold it
	logic [15:0] cfg_timeout  = TIMEOUT_RST;
	logic [7:0]  cfg_seq_min  = SEQ_MIN_RST;
	logic [8:0]  cfg_max_data = MAX_DATA_RST;
	rx_phase_t   rx_phase     = RX_IDLE;
	logic [15:0] tick_cnt     = '0;
	int unsigned got_bytes    = 0;
	logic [15:0] csum         = '0;
	logic [15:0] csum_at_pst  = '0;
	logic [15:0] len_word     = '0;
	logic [7:0]  seq_got      = '0;
	logic [15:0] cmd_got      = '0;
	logic [15:0] bcc_got      = '0;
	logic [63:0] status_acc   = '0;
	logic len_bad = 1'b0, len_ok = 1'b0, cmd_bad = 1'b0, bcc_bad = 1'b0;
	logic pst_bad = 1'b0, sep_bad = 1'b0, stat_bad = 1'b0;
	logic [7:0]  want_seq     = '0;
	logic [15:0] want_cmd     = '0;

	rx_result_t  pending_results[$];
	rx_result_t  oldest;
	logic [7:0]  frame_buf[$];
	int unsigned mismatches   = 0;
	int unsigned items_sent   = 0;
	int unsigned idle_cycles  = 0;
	logic        quiet        = 1'b0;

	function automatic logic is_hex(input logic [7:0] b);
		return b >= HEX_LO && b <= HEX_HI;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] exp);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t mismatch in %s: got %0h, expected %0h", $time, what, got, exp);
	endtask

	task automatic post_verdict(input err_t code);
		rx_result_t v;
		logic [15:0] raw;
		int unsigned dl;
		raw = len_word - LEN_BIAS;
		dl = int'(raw) - LEN_FLOOR;
		v.kind = 1'b1;
		v.data_byte = '0;
		v.data_index = '0;
		v.error_code = code;
		v.resp_seq = seq_got;
		v.resp_cmd = cmd_got;
		v.status_bytes = status_acc;
		v.data_count = (len_ok && dl <= cfg_max_data) ? dl[8:0] : 9'd0;
		pending_results.push_back(v);
		rx_phase = RX_IDLE;
	endtask

	task automatic deframe_step(input logic [1:0] op, input logic [7:0] b,
		input logic [7:0] eseq, input logic [15:0] ecmd);
		int unsigned p, r, dl;
		logic [15:0] raw;
		err_t code;
		rx_result_t d;
		if (op == CMD_START) begin
			tick_cnt = '0;
			got_bytes = 0;
			csum = '0;
			csum_at_pst = '0;
			len_word = '0;
			seq_got = '0;
			cmd_got = '0;
			bcc_got = '0;
			status_acc = '0;
			{len_bad, len_ok, cmd_bad, bcc_bad, pst_bad, sep_bad, stat_bad} = '0;
			want_seq = eseq;
			want_cmd = ecmd;
			rx_phase = RX_HUNT;
			return;
		end
		if (rx_phase == RX_IDLE || op == CMD_UNUSED)
			return;
		if (op == CMD_TICK) begin
			if (tick_cnt != 16'hFFFF)
				tick_cnt++;
			if (tick_cnt >= cfg_timeout)
				post_verdict(E_TIMEOUT);
			return;
		end
		if (rx_phase == RX_HUNT) begin
			if (b == B_NAK) begin
				post_verdict(E_NAK);
			end else if (b == B_SYN) begin
				tick_cnt = '0;
			end else if (b == B_PRE) begin
				rx_phase = RX_FRAME;
				got_bytes = 1;
			end
			return;
		end

		p = got_bytes;
		if (p >= BUF_BYTES) begin
			post_verdict(E_OVERFLOW);
			return;
		end
		got_bytes = p + 1;
		raw = len_word - LEN_BIAS;
		r = 32'(raw);
		dl = r - LEN_FLOOR;
		if (b == B_EOT) begin
			if (got_bytes < FRAME_FLOOR || !len_ok)
				code = E_INVALID;
			else if (dl > cfg_max_data || got_bytes != r + TAIL_LEN)
				code = E_INVALID;
			else if (pst_bad || bcc_bad)
				code = E_INVALID;
			else if (csum_at_pst != bcc_got)
				code = E_BCC;
			else if (seq_got < cfg_seq_min || cmd_bad || sep_bad || stat_bad)
				code = E_INVALID;
			else if (seq_got != want_seq)
				code = E_SEQ;
			else if (cmd_got != want_cmd)
				code = E_CMD;
			else
				code = E_OK;
			post_verdict(code);
			return;
		end
		if (p <= 4) begin
			if (!is_hex(b))
				len_bad = 1'b1;
			len_word = {len_word[11:0], b[3:0]};
			csum = csum + 16'(b);
			raw = len_word - LEN_BIAS;
			if (p == 4 && !len_bad && len_word >= LEN_BIAS && raw >= LEN_FLOOR)
				len_ok = 1'b1;
			return;
		end
		if (p == 5)
			seq_got = b;
		if (p >= 6 && p <= 9) begin
			if (!is_hex(b))
				cmd_bad = 1'b1;
			cmd_got = {cmd_got[11:0], b[3:0]};
		end
		if (!len_ok)
			return;
		if (p <= r)
			csum = csum + 16'(b);
		if (p == r) begin
			csum_at_pst = csum;
			if (b != B_PST)
				pst_bad = 1'b1;
		end
		if (p > r && p <= r + 4) begin
			if (!is_hex(b))
				bcc_bad = 1'b1;
			bcc_got = {bcc_got[11:0], b[3:0]};
		end
		if (p == r - STAT_LEN - 1 && b != B_SEP)
			sep_bad = 1'b1;
		if (p >= r - STAT_LEN && p < r) begin
			if (!b[7])
				stat_bad = 1'b1;
			status_acc = {status_acc[55:0], b};
		end
		if (dl <= cfg_max_data && p >= DATA_POS && p < DATA_POS + dl) begin
			d.kind = 1'b0;
			d.data_byte = b;
			d.data_index = 9'(p - DATA_POS);
			d.error_code = E_OK;
			d.resp_seq = '0;
			d.resp_cmd = '0;
			d.status_bytes = '0;
			d.data_count = '0;
			pending_results.push_back(d);
		end
	endtask

	task automatic send_item(input logic [1:0] op, input logic [7:0] b,
		input logic [7:0] eseq, input logic [15:0] ecmd);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(15);
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.cmd <= op;
		item_ch.rx_byte <= b;
		item_ch.expected_seq <= eseq;
		item_ch.expected_cmd <= ecmd;
		do @(posedge clk); while (!item_ch.ready);
		items_sent++;
		deframe_step(op, b, eseq, ecmd);
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(CMD_BYTE, b, 8'($urandom), 16'($urandom));
	endtask

	task automatic send_tick();
		send_item(CMD_TICK, 8'($urandom), 8'($urandom), 16'($urandom));
	endtask

	task automatic start_rx(input logic [7:0] eseq, input logic [15:0] ecmd);
		send_item(CMD_START, 8'($urandom), eseq, ecmd);
	endtask

	task automatic build_frame(input int unsigned dl, input logic [7:0] seq,
		input logic [15:0] cw);
		logic [15:0] len_val, sum;
		logic [7:0] d;
		len_val = LEN_BIAS + 16'(LEN_FLOOR + dl);
		frame_buf.delete();
		frame_buf.push_back(B_PRE);
		for (int i = 3; i >= 0; i--)
			frame_buf.push_back(HEX_LO + 8'(len_val[4*i +: 4]));
		frame_buf.push_back(seq);
		for (int i = 3; i >= 0; i--)
			frame_buf.push_back(HEX_LO + 8'(cw[4*i +: 4]));
		repeat (dl) begin
			do d = 8'($urandom); while (d == B_EOT);
			frame_buf.push_back(d);
		end
		frame_buf.push_back(B_SEP);
		repeat (STAT_LEN)
			frame_buf.push_back({1'b1, 7'($urandom)});
		frame_buf.push_back(B_PST);
		sum = '0;
		for (int i = 1; i < frame_buf.size(); i++)
			sum = sum + 16'(frame_buf[i]);
		for (int i = 3; i >= 0; i--)
			frame_buf.push_back(HEX_LO + 8'(sum[4*i +: 4]));
		frame_buf.push_back(B_EOT);
	endtask

	task automatic send_frame(input int unsigned tick_pct);
		foreach (frame_buf[i]) begin
			if ($urandom_range(99) < tick_pct)
				send_tick();
			send_byte(frame_buf[i]);
		end
	endtask

	task automatic drain_results();
		item_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [15:0] t, input logic [7:0] s,
		input logic [8:0] m);
		cfg_we <= 1'b1;
		cfg_index <= CFG_TIMEOUT;
		cfg_data <= t;
		@(posedge clk);
		cfg_index <= CFG_SEQ_MIN;
		cfg_data <= {8'h00, s};
		@(posedge clk);
		cfg_index <= CFG_MAX_DATA;
		cfg_data <= {7'h00, m};
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_timeout = t;
		cfg_seq_min = s;
		cfg_max_data = m;
	endtask

	task automatic test_idle_inputs();
		send_byte(B_PRE);
		send_byte(B_EOT);
		send_byte(B_NAK);
		send_tick();
		send_item(CMD_UNUSED, 8'hFF, 8'hFF, 16'hFFFF);
	endtask

	task automatic test_hunting();
		start_rx(8'h00, 16'h0000);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(B_SYN);
		send_item(CMD_UNUSED, 8'h00, 8'h00, 16'h0000);
		send_tick();
		send_byte(B_NAK);
	endtask

	task automatic test_timeout();
		drain_results();
		set_config(16'd0, SEQ_MIN_RST, MAX_DATA_RST);
		start_rx(8'h55, 16'hAAAA);
		send_tick();
		drain_results();
		set_config(16'd2, SEQ_MIN_RST, MAX_DATA_RST);
		start_rx(8'hAA, 16'h5555);
		send_tick();
		send_byte(B_SYN);
		send_tick();
		send_tick();
		build_frame(3, 8'h40, 16'h1234);
		start_rx(8'h40, 16'h1234);
		for (int i = 0; i < 14; i++)
			send_byte(frame_buf[i]);
		send_tick();
		send_tick();
	endtask

	task automatic test_clean_frames();
		drain_results();
		set_config(TIMEOUT_RST, SEQ_MIN_RST, MAX_DATA_RST);
		build_frame(0, 8'hFF, 16'hFFFF);
		start_rx(8'hFF, 16'hFFFF);
		send_frame(0);
		build_frame(5, 8'h20, 16'h0000);
		start_rx(8'h20, 16'h0000);
		send_frame(0);
	endtask

	task automatic test_broken_frames();
		build_frame(4, 8'h31, 16'hBEEF);
		frame_buf[11] = B_EOT;
		start_rx(8'h31, 16'hBEEF);
		send_frame(0);
		start_rx(8'h31, 16'hBEEF);
		send_byte(B_PRE);
		send_byte(B_EOT);
		build_frame(2, 8'h77, 16'hC0DE);
		start_rx(8'h77, 16'hC0DE);
		for (int i = 0; i < 12; i++)
			send_byte(frame_buf[i]);
		start_rx(8'h78, 16'hC0DE);
		send_frame(0);
		build_frame(1, 8'h10, 16'h0101);
		start_rx(8'h10, 16'h0101);
		send_frame(0);
	endtask

	task automatic test_buffer_limits();
		logic [7:0] b;
		drain_results();
		set_config(TIMEOUT_RST, 8'h00, 9'd487);
		build_frame(487, 8'h00, 16'h1234);
		start_rx(8'h00, 16'h1234);
		send_frame(0);
		start_rx(8'h00, 16'h1234);
		send_byte(B_PRE);
		repeat (BUF_BYTES - 1) begin
			do b = 8'($urandom); while (b == B_EOT);
			send_byte(b);
		end
		send_byte(B_EOT);
	endtask

	task automatic run_exchange(input int unsigned tick_pct);
		int unsigned dl, flaw, k;
		logic [7:0] seq, want_s, n;
		logic [15:0] cw, want_c;
		quiet = ($urandom_range(3) == 0);
		flaw = $urandom_range(15);
		seq = (flaw == 15) ? 8'($urandom) : 8'($urandom_range(255, cfg_seq_min));
		cw = 16'($urandom);
		want_s = (flaw == 10) ? seq ^ 8'($urandom_range(255, 1)) : seq;
		want_c = (flaw == 11) ? cw ^ 16'($urandom_range(65535, 1)) : cw;
		dl = ($urandom_range(9) == 0) ? $urandom_range(80) : $urandom_range(12);
		build_frame(dl, seq, cw);
		if ($urandom_range(7) == 0) begin
			send_byte(8'($urandom));
			send_tick();
			send_item(CMD_UNUSED, 8'($urandom), 8'($urandom), 16'($urandom));
		end
		if (flaw == 14) begin
			start_rx(8'($urandom), 16'($urandom));
			k = $urandom_range(frame_buf.size() - 1);
			for (int i = 0; i < k; i++)
				send_byte(frame_buf[i]);
		end
		start_rx(want_s, want_c);
		repeat ($urandom_range(3)) begin
			k = $urandom_range(3);
			if (k == 0) begin
				send_byte(B_SYN);
			end else if (k == 1) begin
				send_tick();
			end else if (k == 2) begin
				send_item(CMD_UNUSED, 8'($urandom), 8'($urandom), 16'($urandom));
			end else begin
				do n = 8'($urandom); while (n == B_PRE || n == B_NAK);
				send_byte(n);
			end
		end
		if (flaw == 13) begin
			send_byte(B_NAK);
			return;
		end
		case (flaw)
			8: frame_buf[$urandom_range(frame_buf.size() - 2, 1)] = 8'($urandom);
			9: begin
				k = frame_buf.size() - 1 - $urandom_range(4, 1);
				frame_buf[k] = frame_buf[k] ^ 8'($urandom_range(15, 1));
			end
			12: frame_buf.delete($urandom_range(frame_buf.size() - 2, 1));
			default: ;
		endcase
		send_frame(tick_pct);
	endtask

	task automatic test_random_traffic();
		int unsigned stop_at;
		for (int ph = 0; ph < 5; ph++) begin
			drain_results();
			case (ph)
				0: set_config(TIMEOUT_RST, SEQ_MIN_RST, MAX_DATA_RST);
				1: set_config(16'hFFFF, 8'h00, 9'd487);
				2: set_config(16'd3, 8'hFF, 9'd0);
				3: set_config(16'($urandom_range(40, 2)), 8'($urandom),
					9'($urandom_range(30)));
				default: set_config(16'd20, 8'h20, 9'd12);
			endcase
			stop_at = items_sent + 100;
			while (items_sent < stop_at)
				run_exchange((ph == 2 || ph == 3) ? 6 : 2);
		end
		quiet = 1'b0;
	endtask

	initial begin : result_sink
		int unsigned stall;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = quiet ? 0 : $urandom_range(15);
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", 64'(result_ch.kind), 64'(0));
			end else begin
				oldest = pending_results.pop_front();
				if (result_ch.kind !== oldest.kind)
					report_mismatch("kind", 64'(result_ch.kind), 64'(oldest.kind));
				if (result_ch.data_byte !== oldest.data_byte)
					report_mismatch("data_byte", 64'(result_ch.data_byte),
						64'(oldest.data_byte));
				if (result_ch.data_index !== oldest.data_index)
					report_mismatch("data_index", 64'(result_ch.data_index),
						64'(oldest.data_index));
				if (result_ch.error_code !== oldest.error_code)
					report_mismatch("error_code", 64'(result_ch.error_code),
						64'(oldest.error_code));
				if (result_ch.resp_seq !== oldest.resp_seq)
					report_mismatch("resp_seq", 64'(result_ch.resp_seq),
						64'(oldest.resp_seq));
				if (result_ch.resp_cmd !== oldest.resp_cmd)
					report_mismatch("resp_cmd", 64'(result_ch.resp_cmd),
						64'(oldest.resp_cmd));
				if (result_ch.status_bytes !== oldest.status_bytes)
					report_mismatch("status_bytes", result_ch.status_bytes,
						oldest.status_bytes);
				if (result_ch.data_count !== oldest.data_count)
					report_mismatch("data_count", 64'(result_ch.data_count),
						64'(oldest.data_count));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		item_ch.valid = 1'b0;
		item_ch.cmd = CMD_TICK;
		item_ch.rx_byte = '0;
		item_ch.expected_seq = '0;
		item_ch.expected_cmd = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_TIMEOUT;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_inputs();
		test_hunting();
		test_timeout();
		test_clean_frames();
		test_broken_frames();
		test_buffer_limits();
		test_random_traffic();
		drain_results();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// ===== ascii_hex_frame_receiver.f =====
design/ahfr_pkg.sv
design/ahfr_if.sv
design/ahfr_front.sv
design/ahfr_queue.sv
design/ahfr_back.sv
design/ascii_hex_frame_receiver.sv
verif/tb.sv
